FILE: src/nps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the nearest point search block: request and
// response payloads, command codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package nps_pkg;

    // Request command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Table slots that the 8-bit slot field can reach
    localparam int SLOT_FIELD_DEPTH = 256;

    // Cycles from the last table read until the best candidate is final
    localparam int DRAIN_CYCLES = 3;

    // Request payload
    typedef struct packed {
        logic               cmd;
        logic [7:0]         slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } nps_req_t;

    // Response payload
    typedef struct packed {
        logic        found;
        logic [7:0]  nearest_slot;
        logic [63:0] distance_squared;
    } nps_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_wr;      // write request point into its slot
        logic query_start;  // latch query position, clear best, rewind scan
        logic scan_en;      // read one slot and advance the scan index
        logic out_load;     // capture the best candidate into the output reg
    } nps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;    // scan index sits on the last table slot
    } nps_status_t;

endpackage

FILE: src/nearest_point_search_core.sv
`timescale 1ns / 1ps
// Load: written at the transfer; the next request is taken in the following cycle.
// Query: all min(POINT_SLOTS,256) table slots are read, one slot per cycle
//   through the single memory read port, then three pipeline stages and a
//   capture into the output register once it is free; one query at a time.
// Loads are taken while a finished response still waits in its register.
// Reset (rst_n low, asynchronous) clears all valid marks and the controller.
// ----------------------------------------------------------------------------
// nearest_point_search_core
// Brute force 2D nearest point search over a table of loaded points,
// built as a sequencer and a pipelined distance datapath.
// ----------------------------------------------------------------------------
module nearest_point_search_core
    import nps_pkg::*;
#(
    parameter int POINT_SLOTS = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  nps_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output nps_rsp_t rsp
);

    nps_cmd_t    cmd;
    nps_status_t status;

    nps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.cmd),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    nps_datapath #(
        .POINT_SLOTS (POINT_SLOTS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule

FILE: src/nps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_ctrl
// Sequencer for the search: accepts loads and queries when idle, steps the
// scan through the table, waits for the datapath pipeline to drain and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module nps_ctrl
    import nps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_cmd,
    output logic        req_stall,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    input  nps_status_t status,
    output nps_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] drain_cnt_reg, drain_cnt_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       req_xfer;
    logic       out_free;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        drain_cnt_next  = drain_cnt_reg;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer && req_cmd == CMD_LOAD)
                begin
                    cmd.load_wr = 1'b1;
                end
                else if (req_xfer && req_cmd == CMD_QUERY)
                begin
                    cmd.query_start = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_last)
                begin
                    drain_cnt_next = '0;
                    state_next     = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_cnt_reg == 2'(DRAIN_CYCLES - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    drain_cnt_next = drain_cnt_reg + 2'd1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on capture, cleared by a transfer
    always_comb
    begin
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            drain_cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drain_cnt_reg <= drain_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

FILE: src/nps_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_datapath
// Point table, valid marks, scan index and the distance pipeline: table read,
// coordinate difference magnitude, squaring, then saturating sum and
// compare against the best candidate so far.
// ----------------------------------------------------------------------------
module nps_datapath
    import nps_pkg::*;
#(
    parameter int POINT_SLOTS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  nps_req_t    req,
    input  nps_cmd_t    cmd,
    output nps_status_t status,
    output nps_rsp_t    rsp
);

    // Only slots below 256 can be loaded, so the table is capped at 256 slots
    localparam int TABLE_DEPTH = (POINT_SLOTS < SLOT_FIELD_DEPTH) ?
                                 POINT_SLOTS : SLOT_FIELD_DEPTH;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Table storage
    logic [31:0]            east_mem  [TABLE_DEPTH];
    logic [31:0]            north_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] slot_valid_reg, slot_valid_next;
    logic                   slot_in_range;
    logic [IDX_W-1:0]       wr_idx;

    // Scan and query
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [31:0]      qx_reg, qy_reg;

    // Stage A: table read
    logic [31:0]      rd_east_reg, rd_north_reg;
    logic             a_live_reg;
    logic [IDX_W-1:0] a_idx_reg;

    // Stage B: difference magnitudes
    logic [32:0]      dx_full, dy_full, dx_neg, dy_neg;
    logic [31:0]      mx_next, my_next, mx_reg, my_reg;
    logic             b_live_reg;
    logic [IDX_W-1:0] b_idx_reg;

    // Stage C: squares
    logic [63:0]      sqx_next, sqy_next, sqx_reg, sqy_reg;
    logic             c_live_reg;
    logic [IDX_W-1:0] c_idx_reg;

    // Stage D: best candidate
    logic [64:0]      dist_sum;
    logic [63:0]      cand_dist;
    logic             better;
    logic             best_found_reg, best_found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [63:0]      best_dist_reg, best_dist_next;

    nps_rsp_t rsp_reg;

    // Load decode
    assign slot_in_range = (int'(req.slot) < TABLE_DEPTH);
    assign wr_idx        = req.slot[IDX_W-1:0];

    // Point memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && slot_in_range)
        begin
            east_mem[wr_idx]  <= req.pos_x;
            north_mem[wr_idx] <= req.pos_y;
        end
        rd_east_reg  <= east_mem[scan_idx_reg];
        rd_north_reg <= north_mem[scan_idx_reg];
    end

    // Valid marks
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (cmd.load_wr && slot_in_range)
        begin
            slot_valid_next[wr_idx] = 1'b1;
        end
    end

    // Scan index
    always_comb
    begin
        priority if (cmd.query_start)
        begin
            scan_idx_next = '0;
        end
        else if (cmd.scan_en)
        begin
            scan_idx_next = (scan_idx_reg == LAST_IDX) ? '0 : scan_idx_reg + IDX_W'(1);
        end
        else
        begin
            scan_idx_next = scan_idx_reg;
        end
    end

    assign status.scan_last = (scan_idx_reg == LAST_IDX);

    // Query position
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            qx_reg <= req.pos_x;
            qy_reg <= req.pos_y;
        end
    end

    // Difference magnitudes; at most 2^32-1, so 32 bits hold them
    assign dx_full = {qx_reg[31], qx_reg} - {rd_east_reg[31], rd_east_reg};
    assign dy_full = {qy_reg[31], qy_reg} - {rd_north_reg[31], rd_north_reg};
    assign dx_neg  = 33'd0 - dx_full;
    assign dy_neg  = 33'd0 - dy_full;
    assign mx_next = dx_full[32] ? dx_neg[31:0] : dx_full[31:0];
    assign my_next = dy_full[32] ? dy_neg[31:0] : dy_full[31:0];

    // Squares, 32x32 each
    assign sqx_next = 64'(mx_reg) * 64'(mx_reg);
    assign sqy_next = 64'(my_reg) * 64'(my_reg);

    // Saturating sum and compare
    assign dist_sum  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign cand_dist = dist_sum[64] ? '1 : dist_sum[63:0];
    assign better    = c_live_reg && (!best_found_reg || (cand_dist < best_dist_reg));

    always_comb
    begin
        priority if (cmd.query_start)
        begin
            best_found_next = 1'b0;
            best_idx_next   = '0;
            best_dist_next  = '0;
        end
        else if (better)
        begin
            best_found_next = 1'b1;
            best_idx_next   = c_idx_reg;
            best_dist_next  = cand_dist;
        end
        else
        begin
            best_found_next = best_found_reg;
            best_idx_next   = best_idx_reg;
            best_dist_next  = best_dist_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        a_idx_reg     <= scan_idx_reg;
        mx_reg        <= mx_next;
        my_reg        <= my_next;
        b_idx_reg     <= a_idx_reg;
        sqx_reg       <= sqx_next;
        sqy_reg       <= sqy_next;
        c_idx_reg     <= b_idx_reg;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            scan_idx_reg   <= '0;
            a_live_reg     <= 1'b0;
            b_live_reg     <= 1'b0;
            c_live_reg     <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            scan_idx_reg   <= scan_idx_next;
            a_live_reg     <= cmd.scan_en && slot_valid_reg[scan_idx_reg];
            b_live_reg     <= a_live_reg;
            c_live_reg     <= b_live_reg;
            best_found_reg <= best_found_next;
        end
    end

    // Output register; best regs are zero when nothing was found
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.found            <= best_found_reg;
            rsp_reg.nearest_slot     <= 8'(best_idx_reg);
            rsp_reg.distance_squared <= best_dist_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: src/nps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_checker
// Port level checks for the nearest point search block, bound to the top.
// ----------------------------------------------------------------------------
module nps_checker
    import nps_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input nps_req_t req,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input nps_rsp_t rsp
);

    // A stalled response stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("response payload changed while stalled");

    // An empty search reports zero slot and zero distance
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.nearest_slot == 8'd0 &&
            rsp.distance_squared == 64'd0)
        else $error("not-found response carries nonzero data");

    // A query transfer blocks requests while the scan runs
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.cmd == CMD_QUERY |=> req_stall)
        else $error("request taken during a scan");

endmodule

bind nearest_point_search_core nps_checker u_nps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
